// File: src/imps_pkg.sv
// shared types for the indexed max priority scheduler
// operation codes, slot table entry layout and controller/datapath handshake structs
// no dependencies

package imps_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_RAISE  = 2'd1,
        OP_LEAVE  = 2'd2,
        OP_SERVE  = 2'd3
    } t_op;

    localparam int PRIO_W  = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;

    typedef struct packed {
        logic                     present;
        logic signed [PRIO_W-1:0] prio;
        logic [STAMP_W-1:0]       stamp;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic cnt_clear;
        logic scan_step;
        logic rd_slot;
        logic raise_calc;
        logic wr_arrive;
        logic wr_leave;
        logic wr_raise;
        logic wr_serve;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic cnt_last;
        logic best_found;
        logic raise_present;
        logic out_free;
    } t_status;

endpackage

// File: src/imps_ctrl.sv
// sequencing controller for the scheduler: clear pass, decode, raise, scan and result
// depends on imps_pkg

module imps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  imps_pkg::t_status i_status,
    output imps_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_DECODE   = 9'b000000100,
        ST_RAISE_RD = 9'b000001000,
        ST_RAISE_WR = 9'b000010000,
        ST_SCAN     = 9'b000100000,
        ST_SCAN_END = 9'b001000000,
        ST_SERVE_WR = 9'b010000000,
        ST_RESULT   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_RESULT;
                if (i_status.op == imps_pkg::OP_SERVE) begin
                    o_cmd.cnt_clear = 1'b1;
                    n_state         = ST_SCAN;
                end else if (i_status.in_range) begin
                    case (i_status.op)
                        imps_pkg::OP_ARRIVE: o_cmd.wr_arrive = 1'b1;
                        imps_pkg::OP_LEAVE:  o_cmd.wr_leave  = 1'b1;
                        imps_pkg::OP_RAISE: begin
                            o_cmd.rd_slot = 1'b1;
                            n_state       = ST_RAISE_RD;
                        end
                        default: n_state = ST_RESULT;
                    endcase
                end
            end
            ST_RAISE_RD: begin
                o_cmd.raise_calc = 1'b1;
                n_state          = ST_RAISE_WR;
            end
            ST_RAISE_WR: begin
                o_cmd.wr_raise = i_status.raise_present;
                n_state        = ST_RESULT;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                // last entry gets compared on this edge
                n_state = ST_SERVE_WR;
            end
            ST_SERVE_WR: begin
                o_cmd.wr_serve = i_status.best_found;
                n_state        = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/imps_dp.sv
// datapath of the scheduler: item registers, action count, slot table memory,
// max search compare and output register; depends on imps_pkg

module imps_dp #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_s_tuser,
    input  logic [39:0]       i_s_tdata,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tuser,
    input  imps_pkg::t_cmd    i_cmd,
    output imps_pkg::t_status o_status
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] CNT_LAST = IW'(SLOTS - 1);

    // item registers
    imps_pkg::t_op                        r_op;
    logic [imps_pkg::SLOT_W-1:0]          r_slot;
    logic signed [imps_pkg::PRIO_W-1:0]   r_amount;
    logic                                 r_in_range;
    logic [imps_pkg::STAMP_W-1:0]         r_count;

    // slot table
    imps_pkg::t_entry r_mem [SLOTS];
    imps_pkg::t_entry r_rd_data;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    imps_pkg::t_entry wr_data;
    logic             wr_en;

    logic [IW-1:0] r_cnt;
    logic [IW-1:0] slot_idx;

    // scan compare pipeline
    logic                               r_cmp_vld;
    logic [IW-1:0]                      r_cmp_idx;
    logic                               r_best_found;
    logic [IW-1:0]                      r_best_idx;
    logic signed [imps_pkg::PRIO_W-1:0] r_best_prio;
    logic [imps_pkg::STAMP_W-1:0]       r_best_stamp;
    logic                               take;

    // raise
    logic signed [imps_pkg::PRIO_W:0]   raise_sum;
    logic signed [imps_pkg::PRIO_W-1:0] raise_sat;
    imps_pkg::t_entry                   r_raise_entry;
    logic                               r_raise_ok;

    // output register
    logic                        r_out_valid;
    logic                        r_out_served;
    logic [imps_pkg::SLOT_W-1:0] r_out_slot;

    assign slot_idx = IW'(r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load && (r_count != '1)) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= imps_pkg::t_op'(i_s_tuser);
            r_slot     <= i_s_tdata[5:0];
            r_amount   <= i_s_tdata[37:6];
            r_in_range <= (32'(i_s_tdata[5:0]) < 32'(SLOTS));
        end
    end

    // sweep counter for the clear pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_step || i_cmd.scan_step) begin
            r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
        end
    end

    assign rd_addr = i_cmd.rd_slot ? slot_idx : r_cnt;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_idx;
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
        end else if (i_cmd.wr_arrive) begin
            wr_en   = 1'b1;
            wr_data = '{present: 1'b1, prio: r_amount, stamp: r_count};
        end else if (i_cmd.wr_leave) begin
            wr_en   = 1'b1;
        end else if (i_cmd.wr_raise) begin
            wr_en   = 1'b1;
            wr_data = r_raise_entry;
        end else if (i_cmd.wr_serve) begin
            wr_en   = 1'b1;
            wr_addr = r_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // saturating add for raise
    assign raise_sum = {r_rd_data.prio[imps_pkg::PRIO_W-1], r_rd_data.prio}
                     + {r_amount[imps_pkg::PRIO_W-1], r_amount};

    always_comb begin
        raise_sat = raise_sum[imps_pkg::PRIO_W-1:0];
        if (raise_sum[imps_pkg::PRIO_W] != raise_sum[imps_pkg::PRIO_W-1]) begin
            raise_sat = raise_sum[imps_pkg::PRIO_W] ? {1'b1, {(imps_pkg::PRIO_W-1){1'b0}}}
                                                    : {1'b0, {(imps_pkg::PRIO_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.raise_calc) begin
            r_raise_entry <= '{present: 1'b1, prio: raise_sat, stamp: r_rd_data.stamp};
            r_raise_ok    <= r_rd_data.present;
        end
    end

    // higher priority wins, then older stamp; strict compare keeps the lower index
    assign take = r_cmp_vld && r_rd_data.present &&
                  (!r_best_found ||
                   (r_rd_data.prio > r_best_prio) ||
                   ((r_rd_data.prio == r_best_prio) && (r_rd_data.stamp < r_best_stamp)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.cnt_clear) begin
                r_best_found <= 1'b0;
            end else if (take) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
        if (take) begin
            r_best_idx   <= r_cmp_idx;
            r_best_prio  <= r_rd_data.prio;
            r_best_stamp <= r_rd_data.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if ((r_op == imps_pkg::OP_SERVE) && r_best_found) begin
                r_out_served <= 1'b1;
                r_out_slot   <= imps_pkg::SLOT_W'(r_best_idx);
            end else begin
                r_out_served <= 1'b0;
                r_out_slot   <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_served;
    assign o_m_tdata  = {2'b00, r_out_slot};

    assign o_status.op            = r_op;
    assign o_status.in_range      = r_in_range;
    assign o_status.cnt_last      = (r_cnt == CNT_LAST);
    assign o_status.best_found    = r_best_found;
    assign o_status.raise_present = r_raise_ok;
    assign o_status.out_free      = !r_out_valid || i_m_tready;

endmodule

// File: src/indexed_max_priority_scheduler_unit.sv
// arrive, leave and out-of-range items go from decode to result; raise adds a slot
// read, a saturating add and a write; serve sweeps the table (one table entry
// compared per cycle), then clears the served slot; results wait for a free output
// one item at a time; input is accepted in the cycle after the result is registered
// reset (i_rst_n low, synchronous): action count cleared, then a clearing pass of all
// SLOTS entries empties the slot table; no input transfer is taken during that pass

module indexed_max_priority_scheduler_unit #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot_id[5:0], amount[37:6], zero pad[39:38]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // served_slot[5:0], zero pad[7:6]
    output logic        m_tuser    // served_valid[0]
);

    imps_pkg::t_cmd    cmd;
    imps_pkg::t_status status;

    imps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    imps_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

// File: tb/tb_indexed_max_priority_scheduler_unit.sv
`timescale 1ns / 1ps
// self-checking bench for indexed_max_priority_scheduler_unit: directed and random scheduling
// traffic with bursty input, output stalls and one long output hold-off, checked in order
// depends on imps_pkg and the scheduler rtl

module tb_indexed_max_priority_scheduler_unit;

    import imps_pkg::*;

    localparam int SLOTS       = 64;
    localparam int TIMEOUT_NS  = 4_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT = 20_000;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } grant_t;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_MASK
    } sink_mode_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // slot_id[5:0], amount[37:6], zero pad[39:38]
    logic [1:0]  s_tuser  = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // served_slot[5:0], zero pad[7:6]
    logic        m_tuser;         // served_valid[0]

    // slot table as the scheduler should hold it
    logic                     tbl_present [SLOTS];
    logic signed [PRIO_W-1:0] tbl_prio    [SLOTS];
    logic [STAMP_W-1:0]       tbl_stamp   [SLOTS];
    logic [STAMP_W-1:0]       act_count;

    grant_t pending_grants[$];

    int  err_count     = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  grants_seen   = 0;
    int  empty_serves  = 0;
    int  sat_hits      = 0;
    int  burst_left    = 0;
    bit  gaps_on       = 1'b1;
    bit  force_ready   = 1'b0;
    bit  hold_req      = 1'b0;
    int  hold_seen     = 0;

    indexed_max_priority_scheduler_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout at %0t with %0d results outstanding", $time, pending_grants.size());
        $display("status: fail");
        $finish;
    end

    // applies one item to the table copy and returns the grant it should produce
    function automatic grant_t schedule_step(t_op op, logic [SLOT_W-1:0] slot,
                                             logic signed [PRIO_W-1:0] amount);
        grant_t g;
        int     best;
        longint sum;
        g    = '0;
        best = -1;
        if (act_count != '1)
            act_count++;
        if (op == OP_SERVE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_present[i] && (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                    (tbl_prio[i] == tbl_prio[best] && tbl_stamp[i] < tbl_stamp[best])))
                    best = i;
            end
            if (best >= 0) begin
                tbl_present[best] = 1'b0;
                g.valid = 1'b1;
                g.slot  = best[SLOT_W-1:0];
                grants_seen++;
            end else begin
                empty_serves++;
            end
        end else if (int'(slot) < SLOTS) begin
            case (op)
                OP_ARRIVE: begin
                    tbl_present[slot] = 1'b1;
                    tbl_prio[slot]    = amount;
                    tbl_stamp[slot]   = act_count;
                end
                OP_RAISE: begin
                    if (tbl_present[slot]) begin
                        sum = longint'(tbl_prio[slot]) + longint'(amount);
                        if (sum > longint'(PRIO_MAX)) begin
                            tbl_prio[slot] = PRIO_MAX;
                            sat_hits++;
                        end else if (sum < longint'(PRIO_MIN)) begin
                            tbl_prio[slot] = PRIO_MIN;
                            sat_hits++;
                        end else begin
                            tbl_prio[slot] = sum[PRIO_W-1:0];
                        end
                    end
                end
                default: begin
                    tbl_present[slot] = 1'b0;
                end
            endcase
        end
        return g;
    endfunction

    task automatic send_item(input t_op op, input logic [SLOT_W-1:0] slot,
                             input logic signed [PRIO_W-1:0] amount);
        grant_t g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 80)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amount, slot};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        g = schedule_step(op, slot, amount);
        pending_grants.insert(pending_grants.size(), g);
        sent_count++;
        burst_left--;
    endtask

    function automatic logic [SLOT_W-1:0] pick_present_slot(logic [SLOT_W-1:0] fallback);
        int live[$];
        for (int i = 0; i < SLOTS; i++)
            if (tbl_present[i])
                live.insert(live.size(), i);
        if (live.size() == 0)
            return fallback;
        return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function automatic logic signed [PRIO_W-1:0] rand_amount(bit narrow);
        case ($urandom_range(0, 9))
            0:       return PRIO_MAX - $urandom_range(0, 2);
            1:       return PRIO_MIN + $urandom_range(0, 2);
            2, 3, 4: return $urandom;
            default: return narrow ? int'($urandom_range(0, 16)) - 8 : $urandom;
        endcase
    endfunction

    task automatic send_random_item(int pool, bit narrow);
        t_op               op;
        logic [SLOT_W-1:0] slot;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = OP_ARRIVE;
        else if (r < 55)
            op = OP_RAISE;
        else if (r < 65)
            op = OP_LEAVE;
        else
            op = OP_SERVE;
        slot = SLOT_W'($urandom_range(0, pool - 1));
        // mostly aim raise and leave at live clients, the rest hit whatever is there
        if ((op == OP_RAISE || op == OP_LEAVE) && $urandom_range(0, 3) != 0)
            slot = pick_present_slot(slot);
        send_item(op, slot, rand_amount(narrow));
    endtask

    // output side: stall modes of its own, plus one long hold-off on request
    initial begin
        sink_mode_t  mode;
        int          mode_left;
        int          hold_left;
        int          ready_pct;
        int          phase;
        logic [15:0] mask;
        mode      = SINK_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        ready_pct = 50;
        phase     = 0;
        mask      = '1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_seen++;
                m_tready <= 1'b0;
            end else if (force_ready) begin
                m_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(50, 400);
                    ready_pct = $urandom_range(20, 90);
                    mask      = 16'($urandom) | 16'h0001;
                end
                mode_left--;
                case (mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= ($urandom_range(0, 99) < ready_pct);
                    default: begin
                        m_tready <= mask[phase];
                        phase     = (phase + 1) % 16;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : grant_check
        grant_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing pending, tuser %0b tdata 0x%0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_grants.pop_front();
                checked_count++;
                if (m_tuser !== want.valid) begin
                    err_count++;
                    $display("%0t: served_valid expected %0b actual %0b",
                             $time, want.valid, m_tuser);
                end
                if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                    err_count++;
                    $display("%0t: served_slot expected %0d actual %0d",
                             $time, want.slot, m_tdata[SLOT_W-1:0]);
                end
                if (m_tdata[7:SLOT_W] !== '0) begin
                    err_count++;
                    $display("%0t: tdata pad expected 0 actual %0b", $time, m_tdata[7:SLOT_W]);
                end
            end
        end
    end

    task automatic test_directed_ops();
        send_item(OP_SERVE, 6'd0, 32'sd0);          // nothing present yet
        send_item(OP_ARRIVE, 6'd0, PRIO_MAX);
        send_item(OP_ARRIVE, 6'd63, PRIO_MIN);
        send_item(OP_ARRIVE, 6'd5, 32'sd0);
        send_item(OP_RAISE, 6'd0, 32'sd1);          // clamps at the top
        send_item(OP_RAISE, 6'd63, -32'sd1);        // clamps at the bottom
        send_item(OP_RAISE, 6'd63, PRIO_MIN);
        send_item(OP_RAISE, 6'd12, 32'sd100);       // absent slot
        send_item(OP_LEAVE, 6'd40, 32'sd0);         // absent slot
        send_item(OP_ARRIVE, 6'd7, PRIO_MAX);       // ties slot 0, later stamp
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_ARRIVE, 6'd5, -32'sd3);        // overwrite a live slot
        send_item(OP_ARRIVE, 6'd9, -32'sd3);
        send_item(OP_RAISE, 6'd9, 32'sd0);
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_LEAVE, 6'd9, 32'sd0);
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_ARRIVE, 6'd1, PRIO_MIN);
        send_item(OP_RAISE, 6'd1, PRIO_MAX);        // lands on -1
        send_item(OP_ARRIVE, 6'd2, -32'sd1);
        send_item(OP_SERVE, 6'd0, 32'sd0);
        send_item(OP_SERVE, 6'd0, 32'sd0);
    endtask

    // output held off long enough that the result register backs up into the input
    task automatic test_output_holdoff();
        hold_req = 1'b1;
        repeat (48)
            send_random_item(SLOTS, 1'b0);
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < SLOTS; i++)
            send_item(OP_ARRIVE, i[SLOT_W-1:0], rand_amount(1'b1));
        repeat (16)
            send_item(OP_RAISE, pick_present_slot(6'd0), rand_amount(1'b1));
        repeat (SLOTS + 1)
            send_item(OP_SERVE, SLOT_W'($urandom), $urandom);
    endtask

    task automatic test_random_traffic(int count, int pool, bit narrow);
        repeat (count)
            send_random_item(pool, narrow);
    endtask

    task automatic test_steady_churn();
        gaps_on     = 1'b0;
        force_ready = 1'b1;
        test_random_traffic(300, 16, 1'b1);
        gaps_on     = 1'b1;
        force_ready = 1'b0;
    endtask

    initial begin
        int drain_guard;
        for (int i = 0; i < SLOTS; i++)
            tbl_present[i] = 1'b0;
        act_count   = '0;
        drain_guard = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_output_holdoff();
        test_fill_and_drain();
        test_random_traffic(500, 8, 1'b1);
        test_random_traffic(700, SLOTS, 1'b0);
        test_steady_churn();

        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0 && drain_guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_guard++;
        end
        repeat (SLOTS + 16) @(posedge i_clk);

        if (pending_grants.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, pending_grants.size());
        end
        $display("ran %0d scheduling items, %0d results checked: %0d grants, %0d empty serves",
                 sent_count, checked_count, grants_seen, empty_serves);
        $display("priority clamps on raise: %0d, output hold-off cycles: %0d",
                 sat_hits, hold_seen);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", err_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
